FILE: hdl/aesbc_pkg.sv
// aesbc_pkg: shared types, constants and byte functions of the aes block cipher
// holds the s-box tables, galois field helpers and the transfer structs
// no dependencies
`default_nettype none

package aesbc_pkg;

    localparam int unsigned RowWidth = 128;
    localparam int unsigned RowDepth = 15;
    localparam int unsigned RowAddrW = 4;
    localparam int unsigned WinCells = 8;

    typedef struct packed {
        logic        command;
        logic [63:0] block_upper;
        logic [63:0] block_lower;
    } item_t;

    typedef struct packed {
        logic [63:0] result_upper;
        logic [63:0] result_lower;
        logic        key_error;
    } result_t;

    typedef struct packed {
        logic decrypt;
        logic last;
    } round_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = xtime(x);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/aesbc_ram.sv
// aesbc_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module aesbc_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/aesbc_kcell.sv
// aesbc_kcell: one word cell of the key expansion window chain
// no dependencies
`default_nettype none

module aesbc_kcell (
    input  wire logic        clk,
    input  wire logic        shift,
    input  wire logic [31:0] d,
    output logic      [31:0] q
);

    logic [31:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

`default_nettype wire

FILE: hdl/aesbc_round.sv
// aesbc_round: one full aes round, forward or inverse, combinational
// depends on aesbc_pkg
`default_nettype none

module aesbc_round (
    input  wire logic [127:0]            st,
    input  wire logic [127:0]            rkey,
    input  wire aesbc_pkg::round_ctl_t   ctl,
    output logic      [127:0]            st_next
);
    import aesbc_pkg::*;

    always_comb
    begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] k [16];
        logic [7:0] m [16];
        for (int n = 0; n < 16; n++)
        begin
            s[n] = st[127-8*n -: 8];
            k[n] = rkey[127-8*n -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (ctl.decrypt)
                begin
                    t[((c + r) % 4) * 4 + r] = INV_SBOX[s[4*c+r]];
                end
                else
                begin
                    t[4*c+r] = SBOX[s[((c + r) % 4) * 4 + r]];
                end
            end
        end
        // inverse round keys are added before the column mix
        if (ctl.decrypt)
        begin
            for (int n = 0; n < 16; n++)
            begin
                t[n] = t[n] ^ k[n];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (ctl.decrypt)
                begin
                    m[4*c+r] = gmul(t[4*c+r], 4'd14) ^ gmul(t[4*c+(r+1)%4], 4'd11)
                             ^ gmul(t[4*c+(r+2)%4], 4'd13) ^ gmul(t[4*c+(r+3)%4], 4'd9);
                end
                else
                begin
                    m[4*c+r] = gmul(t[4*c+r], 4'd2) ^ gmul(t[4*c+(r+1)%4], 4'd3)
                             ^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4];
                end
            end
        end
        for (int n = 0; n < 16; n++)
        begin
            if (ctl.last)
            begin
                st_next[127-8*n -: 8] = ctl.decrypt ? t[n] : (t[n] ^ k[n]);
            end
            else
            begin
                st_next[127-8*n -: 8] = ctl.decrypt ? m[n] : (m[n] ^ k[n]);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/aes_block_cipher.sv
// aes_block_cipher: top level of the aes-128/192/256 ecb block cipher
// depends on aesbc_pkg, aesbc_ram, aesbc_kcell and aesbc_round
`default_nettype none

// usage
//  - command channel: an item transfer happens at a rising edge with start high
//    and busy low; item carries command (0 encrypt, 1 decrypt) and the block
//  - result channel: done is high for exactly one cycle with the result; the
//    receiver cannot stall, so the result must be taken in that cycle
//  - config: apb port, register i at byte address 8*i, 64-bit data, pready tied
//    high; writes only while the block is idle; any write drops the round keys
// timing
//  - first block after a config write: the key is expanded one word per cycle
//    through the window cell chain, 44, 52 or 60 words for 128/192/256 bits
//  - each block: the first round key row is fetched, then that key is added and one
//    aes round runs per cycle; done rises in the cycle after the last round, as busy
//    drops
//  - a key that is too long gives done in the cycle after the transfer with a zero
//    result and key_error set, without expansion
// reset
//  - rst_n is asynchronous, active low; registers go to key size 128, 16 given
//    key bytes and zero key, round keys marked stale; the key store has no clear
module aes_block_cipher (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire aesbc_pkg::item_t   item,
    output logic                    busy,
    output logic                    done,
    output aesbc_pkg::result_t      result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready
);
    import aesbc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_PREP   = 2'd2;
    localparam logic [1:0] ST_ROUND  = 2'd3;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_GIVEN = 3'd1;
    localparam logic [2:0] REG_KEY0  = 3'd2;
    localparam logic [2:0] REG_KEY1  = 3'd3;
    localparam logic [2:0] REG_KEY2  = 3'd4;
    localparam logic [2:0] REG_KEY3  = 3'd5;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [5:0]  given_reg;
    logic [63:0] key_reg [4];
    logic        keys_ready_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:  prdata = {62'd0, mode_reg};
            REG_GIVEN: prdata = {58'd0, given_reg};
            REG_KEY0:  prdata = key_reg[0];
            REG_KEY1:  prdata = key_reg[1];
            REG_KEY2:  prdata = key_reg[2];
            REG_KEY3:  prdata = key_reg[3];
            default:   prdata = 64'd0;
        endcase
    end

    // key geometry, mode 3 runs as 256-bit
    logic [1:0] mode_eff;
    logic [3:0] nk;
    logic [3:0] nr;
    logic [5:0] key_len;
    logic [5:0] total_words;
    logic       key_err;
    logic [7:0] pad_byte;

    assign mode_eff    = (mode_reg == 2'd3) ? 2'd2 : mode_reg;
    assign nk          = 4'd4 + {1'b0, mode_eff, 1'b0};
    assign nr          = 4'd10 + {1'b0, mode_eff, 1'b0};
    assign key_len     = {nk, 2'b00};
    assign total_words = {nr, 2'b00} + 6'd4;
    assign key_err     = given_reg > key_len;
    assign pad_byte    = {2'b00, key_len - given_reg};

    // sequencer
    logic [1:0]   state_reg, state_next;
    logic         dec_reg;
    logic [127:0] blk_reg;
    logic [127:0] st_reg, st_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         done_reg, done_next;
    result_t      res_reg, res_next;

    // key expansion
    logic [5:0]   widx_reg;
    logic [2:0]   pos_reg;
    logic [3:0]   rc_reg;
    logic [31:0]  buf_reg [3];
    logic [31:0]  win_q [WinCells];
    logic [31:0]  new_word;
    logic         win_shift;

    // round key store
    logic                ram_we;
    logic [RowAddrW-1:0] ram_waddr;
    logic [RowWidth-1:0] ram_wdata;
    logic [RowAddrW-1:0] ram_raddr;
    logic [RowWidth-1:0] ram_rdata;

    logic       accept;
    logic       exp_last;
    round_ctl_t rctl;
    logic [127:0] round_out;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = state_reg != ST_IDLE;
    assign done     = done_reg;
    assign result   = res_reg;
    assign exp_last = widx_reg == (total_words - 6'd1);
    assign win_shift = state_reg == ST_EXPAND;

    // next key word from the window: w[i-1] in cell 0, w[i-nk] in cell nk-1
    always_comb
    begin
        logic [255:0] key_all;
        logic [31:0]  t;
        logic [31:0]  far;
        logic [4:0]   bidx;
        key_all = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
        t       = win_q[0];
        bidx    = 5'd0;
        unique case (mode_eff)
            2'd0:    far = win_q[3];
            2'd1:    far = win_q[5];
            default: far = win_q[7];
        endcase
        if (widx_reg < {2'b00, nk})
        begin
            for (int b = 0; b < 4; b++)
            begin
                bidx = {widx_reg[2:0], 2'(b)};
                new_word[31-8*b -: 8] = ({1'b0, bidx} < given_reg)
                                      ? key_all[8*(31 - bidx) +: 8] : pad_byte;
            end
        end
        else
        begin
            if (pos_reg == 3'd0)
            begin
                t = sub_word({t[23:0], t[31:24]})
                  ^ {(rc_reg < 4'd10) ? RCON[rc_reg] : 8'h00, 24'd0};
            end
            else if ((mode_eff == 2'd2) && (pos_reg == 3'd4))
            begin
                t = sub_word(t);
            end
            new_word = far ^ t;
        end
    end

    for (genvar g = 0; g < WinCells; g++)
    begin : g_win
        aesbc_kcell u_cell (
            .clk   (clk),
            .shift (win_shift),
            .d     ((g == 0) ? new_word : win_q[(g == 0) ? 0 : g - 1]),
            .q     (win_q[g])
        );
    end

    assign ram_we    = (state_reg == ST_EXPAND) && (widx_reg[1:0] == 2'd3);
    assign ram_waddr = widx_reg[5:2];
    assign ram_wdata = {buf_reg[0], buf_reg[1], buf_reg[2], new_word};

    // round key row for a step count: forward runs up, inverse runs down
    function automatic logic [3:0] row_of(input logic d, input logic [3:0] c,
                                          input logic [3:0] rounds);
        return d ? (rounds - c) : c;
    endfunction

    always_comb
    begin
        if (state_reg == ST_PREP)
        begin
            ram_raddr = row_of(dec_reg, 4'd0, nr);
        end
        else
        begin
            ram_raddr = row_of(dec_reg, cnt_reg + 4'd1, nr);
        end
    end

    aesbc_ram #(
        .WIDTH (RowWidth),
        .DEPTH (RowDepth)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rctl.decrypt = dec_reg;
    assign rctl.last    = cnt_reg == nr;

    aesbc_round u_round (
        .st      (st_reg),
        .rkey    (ram_rdata),
        .ctl     (rctl),
        .st_next (round_out)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (key_err)
                    begin
                        done_next = 1'b1;
                        res_next  = '{result_upper: 64'd0, result_lower: 64'd0,
                                      key_error: 1'b1};
                    end
                    else if (keys_ready_reg)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        state_next = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                if (exp_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next   = 4'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    st_next = blk_reg ^ ram_rdata;
                end
                else
                begin
                    st_next = round_out;
                end
                if (rctl.last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    res_next   = '{result_upper: round_out[127:64],
                                  result_lower: round_out[63:0], key_error: 1'b0};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            keys_ready_reg <= 1'b0;
            mode_reg       <= 2'd0;
            given_reg      <= 6'd16;
            key_reg[0]     <= 64'd0;
            key_reg[1]     <= 64'd0;
            key_reg[2]     <= 64'd0;
            key_reg[3]     <= 64'd0;
            widx_reg       <= 6'd0;
            pos_reg        <= 3'd0;
            rc_reg         <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_wr && (cfg_idx <= REG_KEY3))
            begin
                keys_ready_reg <= 1'b0;
                unique case (cfg_idx)
                    REG_MODE:  mode_reg   <= pwdata[1:0];
                    REG_GIVEN: given_reg  <= pwdata[5:0];
                    REG_KEY0:  key_reg[0] <= pwdata;
                    REG_KEY1:  key_reg[1] <= pwdata;
                    REG_KEY2:  key_reg[2] <= pwdata;
                    default:   key_reg[3] <= pwdata;
                endcase
            end
            else if ((state_reg == ST_EXPAND) && exp_last)
            begin
                keys_ready_reg <= 1'b1;
            end
            if (state_reg == ST_EXPAND)
            begin
                widx_reg <= widx_reg + 6'd1;
                if (pos_reg == nk[2:0] - 3'd1 || (mode_eff == 2'd2 && pos_reg == 3'd7))
                begin
                    pos_reg <= 3'd0;
                    if (widx_reg >= {2'b00, nk})
                    begin
                        rc_reg <= rc_reg + 4'd1;
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + 3'd1;
                end
            end
            else
            begin
                widx_reg <= 6'd0;
                pos_reg  <= 3'd0;
                rc_reg   <= 4'd0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        st_reg  <= st_next;
        res_reg <= res_next;
        if (accept)
        begin
            dec_reg <= item.command;
            blk_reg <= {item.block_upper, item.block_lower};
        end
        if (state_reg == ST_EXPAND)
        begin
            unique case (widx_reg[1:0])
                2'd0:    buf_reg[0] <= new_word;
                2'd1:    buf_reg[1] <= new_word;
                2'd2:    buf_reg[2] <= new_word;
                default: buf_reg[2] <= buf_reg[2];
            endcase
        end
    end

`ifndef ASSERT_OFF
    // an error result never carries data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.key_error |-> (result.result_upper == 64'd0)
                                   && (result.result_lower == 64'd0))
        else $error("key error result carries data");

    // a transfer with a valid key makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !key_err |=> busy)
        else $error("transfer not followed by busy");

    // the round key store is written only during expansion
    a_store_wr: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXPAND) && !keys_ready_reg)
        else $error("round key store written outside expansion");

    // a result appears only as the block goes idle or right after an error transfer
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");
`endif

endmodule

`default_nettype wire
